/* hw/rtl/linear_probe_hash_table_assert.svh */
// assertion macros for the hash table
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg)
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/lpht_pkg.sv */
package lpht_pkg;

    localparam int DEFAULT_SLOTS = 1024;

    localparam int KEY_W    = 31;
    localparam int TAG_W    = 32;
    localparam int CFG_W    = 11;
    localparam int SLOT_W   = 10;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int BIT_W    = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_GONE  = 2'd2;

    localparam logic [STAT_W-1:0] RES_OK   = 2'd0;
    localparam logic [STAT_W-1:0] RES_MISS = 2'd1;
    localparam logic [STAT_W-1:0] RES_FULL = 2'd2;

endpackage

/* hw/rtl/linear_probe_hash_table.sv */
// linear probing hash table with tombstones
// input channel: i_valid / o_ready carries one transaction of i_action, i_key and
// i_name_tag (add, remove or search); output channel: o_valid / i_ready carries
// one transaction of o_status and o_slot per request.
// i_cfg_we / i_cfg_wdata set the slot count m, clamped to 1..SLOTS; write it only
// while no request is in flight.
// a request goes through an accept step, then the key modulo m in the shared
// compare-subtract unit (one key bit per cycle), then a memory read and a check
// per probed slot, and last the hand-off of the result; it makes p probes, p
// between 1 and m. an unused action skips straight to the hand-off. one request
// is worked on at a time; o_ready is high only when idle.
// the result sits in an output register, so a new request is taken while the
// receiver stalls; a finished request then waits until that register frees up.
// reset: synchronous active-low; afterwards a clearing pass marks every slot
// empty, o_ready stays low during it and config writes are still taken.
module linear_probe_hash_table #(
    parameter int SLOTS = lpht_pkg::DEFAULT_SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lpht_pkg::ACT_W-1:0]  i_action,
    input  logic [lpht_pkg::KEY_W-1:0]  i_key,
    input  logic [lpht_pkg::TAG_W-1:0]  i_name_tag,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lpht_pkg::STAT_W-1:0] o_status,
    output logic [lpht_pkg::SLOT_W-1:0] o_slot
);
    import lpht_pkg::*;

    localparam int W = $clog2(SLOTS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [1:0]       mem_status [SLOTS];
    logic [KEY_W-1:0] mem_key    [SLOTS];
    logic [TAG_W-1:0] mem_tag    [SLOTS];

    logic [2:0]        r_state,      n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [ACT_W-1:0]  r_action,     n_action;
    logic [KEY_W-1:0]  r_key,        n_key;
    logic [TAG_W-1:0]  r_tag,        n_tag;
    logic [BIT_W-1:0]  r_bit,        n_bit;
    logic [W-1:0]      r_rem,        n_rem;
    logic [W-1:0]      r_pos,        n_pos;
    logic [W-1:0]      r_home,       n_home;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [SLOT_W-1:0] r_res_slot,   n_res_slot;
    logic              r_out_valid,  n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0] r_out_slot,   n_out_slot;
    logic [1:0]        r_rd_status;
    logic [KEY_W-1:0]  r_rd_key;
    logic [TAG_W-1:0]  r_rd_tag;

    logic [31:0]       w_m32;
    logic [31:0]       w_alu_a;
    logic [31:0]       w_alu_res;
    logic              w_alu_ge;
    logic [W-1:0]      w_step;
    logic [31:0]       w_pos32;
    logic [SLOT_W-1:0] w_pos_slot;
    logic              w_hit;
    logic              w_lap_end;
    logic              w_st_we;
    logic [1:0]        w_st_wdata;
    logic              w_data_we;

    // effective slot count
    always_comb begin
        if (r_cfg == '0) begin
            w_m32 = 32'd1;
        end else if (32'(r_cfg) > 32'(SLOTS)) begin
            w_m32 = 32'(SLOTS);
        end else begin
            w_m32 = 32'(r_cfg);
        end
    end

    // shared compare-subtract unit: modulo steps and wrapping probe increments
    assign w_alu_a   = (r_state == S_MOD) ? 32'({r_rem, r_key[r_bit]}) : 32'(r_pos) + 32'd1;
    assign w_alu_ge  = (w_alu_a >= w_m32);
    assign w_alu_res = w_alu_ge ? (w_alu_a - w_m32) : w_alu_a;
    assign w_step    = w_alu_res[W-1:0];

    assign w_pos32    = 32'(r_pos);
    assign w_pos_slot = w_pos32[SLOT_W-1:0];
    assign w_hit      = (r_rd_status == ST_USED) && (r_rd_key == r_key) && (r_rd_tag == r_tag);
    assign w_lap_end  = (w_step == r_home);

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_key        = r_key;
        n_tag        = r_tag;
        n_bit        = r_bit;
        n_rem        = r_rem;
        n_pos        = r_pos;
        n_home       = r_home;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        w_st_we      = 1'b0;
        w_st_wdata   = ST_EMPTY;
        w_data_we    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_st_we    = 1'b1;
                w_st_wdata = ST_EMPTY;
                if (r_pos == W'(SLOTS - 1)) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_action = i_action;
                    n_key    = i_key;
                    n_tag    = i_name_tag;
                    if (i_action == ACT_NONE) begin
                        n_res_status = RES_MISS;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_rem   = '0;
                        n_bit   = BIT_W'(KEY_W - 1);
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_rem = w_step;
                if (r_bit == '0) begin
                    n_pos   = w_step;
                    n_home  = w_step;
                    n_state = S_READ;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_action == ACT_ADD) begin
                    if (r_rd_status == ST_EMPTY) begin
                        w_st_we      = 1'b1;
                        w_st_wdata   = ST_USED;
                        w_data_we    = 1'b1;
                        n_res_status = RES_OK;
                        n_res_slot   = w_pos_slot;
                        n_state      = S_DONE;
                    end else if (w_lap_end) begin
                        n_res_status = RES_FULL;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_pos   = w_step;
                        n_state = S_READ;
                    end
                end else begin
                    if (r_rd_status == ST_EMPTY) begin
                        n_res_status = RES_MISS;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else if (w_hit) begin
                        if (r_action == ACT_REMOVE) begin
                            w_st_we    = 1'b1;
                            w_st_wdata = ST_GONE;
                        end
                        n_res_status = RES_OK;
                        n_res_slot   = w_pos_slot;
                        n_state      = S_DONE;
                    end else if (w_lap_end) begin
                        n_res_status = RES_MISS;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_pos   = w_step;
                        n_state = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_pos   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_key        <= n_key;
        r_tag        <= n_tag;
        r_bit        <= n_bit;
        r_rem        <= n_rem;
        r_home       <= n_home;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    // slot memories, one port at the probe position
    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            mem_status[r_pos] <= w_st_wdata;
        end
        r_rd_status <= mem_status[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            mem_key[r_pos] <= r_key;
            mem_tag[r_pos] <= r_tag;
        end
        r_rd_key <= mem_key[r_pos];
        r_rd_tag <= mem_tag[r_pos];
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_slot   = r_out_slot;

`include "linear_probe_hash_table_assert.svh"

    `LPHT_ASSERT_IMP(a_probe_in_range, (r_state == S_READ) || (r_state == S_CHECK), w_pos32 < w_m32, "probe position beyond slot count")
    `LPHT_ASSERT_IMP(a_rem_in_range, r_state == S_MOD, 32'(r_rem) < w_m32, "modulo remainder not below slot count")
    `LPHT_ASSERT_NXT(a_accept_moves_on, i_valid && o_ready, (r_state == S_MOD) || (r_state == S_DONE), "accepted request did not start")
    `LPHT_ASSERT_IMP(a_used_only_on_add, w_st_we && (w_st_wdata == ST_USED), (r_action == ACT_ADD) && (r_state == S_CHECK), "slot marked used outside an add")

endmodule
